### rtl/byte_ring_deque_assert.svh
// assertion macros used by the ring deque control module
// the using module provides clk and rst_n
`ifndef BYTE_RING_DEQUE_ASSERT_SVH
`define BYTE_RING_DEQUE_ASSERT_SVH

// same-cycle implication
`define BRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define BRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/brd_pkg.sv
package brd_pkg;

  localparam int DEPTH_DEF = 256;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_IDX   = 3'd4,
    OP_WRITE_IDX  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [7:0] position;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic [8:0] occupancy;
  } rsp_t;

  // response info held while the store read completes
  typedef struct packed {
    logic       valid;
    logic       rd;
    status_t    status;
    logic [8:0] occupancy;
  } pend_t;

endpackage

### rtl/brd_ram.sv
module brd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brd_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/brd_ctrl.sv
`include "byte_ring_deque_assert.svh"

module brd_ctrl #(
  parameter int DEPTH = brd_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  brd_pkg::req_t            in_req,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_addr,
  output logic [7:0]               mem_wdata,
  output brd_pkg::pend_t           pend
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  logic [PW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           busy_r;
  brd_pkg::pend_t pend_r, pend_nxt;

  logic          acc;
  logic          full, empty, in_range;
  logic [PW-1:0] head_dec, head_inc;
  logic [PW-1:0] lidx;
  logic [PW:0]   sum;
  logic [PW-1:0] slot;
  logic          use_dec;

  assign acc   = start && !busy_r;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign in_range = (XW'(in_req.position) < XW'(count_r));

  assign head_dec = (head_r == '0) ? PW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // physical slot = (head + logical) mod DEPTH, sum stays below 2*DEPTH
  assign sum  = {1'b0, head_r} + {1'b0, lidx};
  assign slot = (sum >= (PW+1)'(DEPTH)) ? PW'(sum - (PW+1)'(DEPTH)) : sum[PW-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    lidx      = '0;
    use_dec   = 1'b0;
    mem_we    = 1'b0;
    pend_nxt  = '0;
    pend_nxt.status = brd_pkg::ST_OK;
    if (acc) begin
      unique case (brd_pkg::op_t'(in_req.op))
        brd_pkg::OP_PUSH_BACK: begin
          if (full) begin
            pend_nxt.status = brd_pkg::ST_FULL;
          end else begin
            lidx      = PW'(count_r);
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        brd_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            pend_nxt.status = brd_pkg::ST_FULL;
          end else begin
            use_dec   = 1'b1;
            mem_we    = 1'b1;
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        brd_pkg::OP_POP_BACK: begin
          if (empty) begin
            pend_nxt.status = brd_pkg::ST_EMPTY;
          end else begin
            lidx        = PW'(count_r - 1'b1);
            pend_nxt.rd = 1'b1;
            count_nxt   = count_r - 1'b1;
          end
        end
        brd_pkg::OP_POP_FRONT: begin
          if (empty) begin
            pend_nxt.status = brd_pkg::ST_EMPTY;
          end else begin
            pend_nxt.rd = 1'b1;
            head_nxt    = head_inc;
            count_nxt   = count_r - 1'b1;
          end
        end
        brd_pkg::OP_READ_IDX: begin
          if (!in_range) begin
            pend_nxt.status = brd_pkg::ST_RANGE;
          end else begin
            lidx        = PW'(XW'(in_req.position));
            pend_nxt.rd = 1'b1;
          end
        end
        brd_pkg::OP_WRITE_IDX: begin
          if (!in_range) begin
            pend_nxt.status = brd_pkg::ST_RANGE;
          end else begin
            lidx   = PW'(XW'(in_req.position));
            mem_we = 1'b1;
          end
        end
        default: begin
          // unused codes leave everything as is
        end
      endcase
      pend_nxt.valid     = 1'b1;
      pend_nxt.occupancy = 9'(count_nxt);
    end
  end

  assign mem_addr  = use_dec ? head_dec : slot;
  assign mem_wdata = in_req.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      busy_r  <= 1'b1;
      pend_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      busy_r  <= 1'b0;
      pend_r  <= pend_nxt;
    end
  end

  assign busy = busy_r;
  assign pend = pend_r;

  `BRD_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `BRD_ASSERT_IMP(a_head_bound, 1'b1, head_r <= PW'(DEPTH - 1))
  `BRD_ASSERT_IMP(a_we_needs_item, mem_we, acc && !pend_nxt.rd)
  `BRD_ASSERT_NXT(a_count_quiet, !acc, $stable(count_r) && $stable(head_r) && !pend_r.valid)
  `BRD_ASSERT_NXT(a_pop_reads, acc && !empty && (in_req.op == brd_pkg::OP_POP_FRONT),
                  pend_r.valid && pend_r.rd && (count_r == $past(count_r) - 1'b1))

endmodule

### rtl/byte_ring_deque.sv
// Byte deque of DEPTH entries kept in one circular store with a front
// pointer and an element count. A request is taken on start while busy is
// low; busy is high only during reset and in the cycle after it, so
// one request can be issued every cycle. Each request gives exactly one result, with out_valid
// high for one cycle, in the cycle after the request is taken: the store has a
// registered read port and the popped or read byte comes straight from it.
// Results cannot be held off, the receiver must take them when strobed.
// Pushes to a full deque, pops from an empty one and index accesses at or
// past the count report a status and change nothing.
module byte_ring_deque #(
  parameter int DEPTH = brd_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  brd_pkg::req_t in_req,
  output logic          out_valid,
  output brd_pkg::rsp_t out_rsp
);

  localparam int PW = $clog2(DEPTH);

  logic           mem_we;
  logic [PW-1:0]  mem_addr;
  logic [7:0]     mem_wdata;
  logic [7:0]     mem_rdata;
  brd_pkg::pend_t pend;

  brd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .pend     (pend)
  );

  brd_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    out_valid         = pend.valid;
    out_rsp.data      = pend.rd ? mem_rdata : 8'd0;
    out_rsp.status    = pend.status;
    out_rsp.occupancy = pend.occupancy;
  end

endmodule

### bench/tb_byte_ring_deque.sv
`timescale 1ns / 100ps

module tb_byte_ring_deque;

  localparam int CAP = brd_pkg::DEPTH_DEF;
  localparam int ITEMS = 1900;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX = 2;
  // op codes the block leaves unused
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // mirror of the deque contents plus the responses still owed by the block
  class deque_tracker;
    bit [7:0]      ring [CAP];
    int            front = 0;
    int            count = 0;
    int            errors = 0;
    int            seen = 0;
    brd_pkg::rsp_t owed [$];

    function int slot(int idx);
      return (front + idx) % CAP;
    endfunction

    function brd_pkg::rsp_t apply_op(brd_pkg::req_t r);
      brd_pkg::rsp_t rsp;
      rsp.data = '0;
      rsp.status = brd_pkg::ST_OK;
      case (r.op)
        brd_pkg::OP_PUSH_BACK: begin
          if (count == CAP) begin
            rsp.status = brd_pkg::ST_FULL;
          end else begin
            ring[slot(count)] = r.value;
            count++;
          end
        end
        brd_pkg::OP_PUSH_FRONT: begin
          if (count == CAP) begin
            rsp.status = brd_pkg::ST_FULL;
          end else begin
            front = (front + CAP - 1) % CAP;
            ring[front] = r.value;
            count++;
          end
        end
        brd_pkg::OP_POP_BACK: begin
          if (count == 0) begin
            rsp.status = brd_pkg::ST_EMPTY;
          end else begin
            count--;
            rsp.data = ring[slot(count)];
          end
        end
        brd_pkg::OP_POP_FRONT: begin
          if (count == 0) begin
            rsp.status = brd_pkg::ST_EMPTY;
          end else begin
            rsp.data = ring[front];
            front = (front + 1) % CAP;
            count--;
          end
        end
        brd_pkg::OP_READ_IDX: begin
          if (int'(r.position) >= count) rsp.status = brd_pkg::ST_RANGE;
          else rsp.data = ring[slot(r.position)];
        end
        brd_pkg::OP_WRITE_IDX: begin
          if (int'(r.position) >= count) rsp.status = brd_pkg::ST_RANGE;
          else ring[slot(r.position)] = r.value;
        end
        default: ;
      endcase
      rsp.occupancy = count[8:0];
      return rsp;
    endfunction

    function void note_request(brd_pkg::req_t r);
      owed = {owed, apply_op(r)};
    endfunction

    task log_mismatch(string msg);
      $display("%0t ns: result %0d: %s", $realtime, seen, msg);
      errors++;
    endtask

    task check_response(brd_pkg::rsp_t got);
      brd_pkg::rsp_t want;
      if (owed.size() == 0) begin
        log_mismatch("result with no item outstanding");
      end else begin
        want = owed[0];
        owed.delete(0);
        if (got.data !== want.data)
          log_mismatch($sformatf("data %0h, want %0h", got.data, want.data));
        if (got.status !== want.status)
          log_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.occupancy !== want.occupancy)
          log_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      end
      seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  brd_pkg::req_t in_req;
  logic out_valid;
  brd_pkg::rsp_t out_rsp;

  deque_tracker tr = new();

  byte_ring_deque dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_rsp(out_rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) tr.check_response(out_rsp);
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  task send(brd_pkg::req_t r);
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    tr.note_request(r);
  endtask

  task send_op(logic [2:0] op, logic [7:0] value, logic [7:0] position);
    brd_pkg::req_t r;
    r.op = op;
    r.value = value;
    r.position = position;
    send(r);
  endtask

  // random item leaning toward growing, shrinking or neither
  function brd_pkg::req_t pick(int mode);
    brd_pkg::req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r.value = 8'($urandom_range(0, 255));
    r.position = 8'($urandom_range(0, 255));
    if (roll < 2) begin
      r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else if (roll < 22) begin
      r.op = $urandom_range(0, 1) ? brd_pkg::OP_READ_IDX : brd_pkg::OP_WRITE_IDX;
      if (tr.count > 0 && $urandom_range(0, 99) < 85)
        r.position = 8'($urandom_range(0, tr.count - 1));
    end else begin
      roll = $urandom_range(0, 99);
      if ((mode == MODE_FILL && roll < 88) || (mode == MODE_DRAIN && roll < 12) ||
          (mode == MODE_MIX && roll < 50))
        r.op = $urandom_range(0, 1) ? brd_pkg::OP_PUSH_BACK : brd_pkg::OP_PUSH_FRONT;
      else
        r.op = $urandom_range(0, 1) ? brd_pkg::OP_POP_BACK : brd_pkg::OP_POP_FRONT;
    end
    return r;
  endfunction

  initial begin
    int sent;
    int burst_left;
    int gap;
    int mode;
    int linger;
    int mix_left;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, out of range, both ends, index access, unused codes
    send_op(brd_pkg::OP_POP_BACK, 8'h00, 8'h00);
    send_op(brd_pkg::OP_POP_FRONT, 8'hff, 8'hff);
    send_op(brd_pkg::OP_READ_IDX, 8'h00, 8'h00);
    send_op(brd_pkg::OP_WRITE_IDX, 8'hff, 8'hff);
    send_op(brd_pkg::OP_PUSH_BACK, 8'h00, 8'h00);
    send_op(brd_pkg::OP_PUSH_FRONT, 8'hff, 8'hff);
    send_op(brd_pkg::OP_PUSH_BACK, 8'ha5, 8'h00);
    send_op(brd_pkg::OP_READ_IDX, 8'h00, 8'h00);
    send_op(brd_pkg::OP_READ_IDX, 8'h00, 8'h02);
    send_op(brd_pkg::OP_WRITE_IDX, 8'h5a, 8'h01);
    send_op(brd_pkg::OP_READ_IDX, 8'h00, 8'h01);
    send_op(brd_pkg::OP_READ_IDX, 8'h00, 8'hff);
    send_op(brd_pkg::OP_WRITE_IDX, 8'h33, 8'h03);
    send_op(OP_SPARE_A, 8'hff, 8'hff);
    send_op(OP_SPARE_B, 8'h00, 8'h00);
    send_op(brd_pkg::OP_POP_FRONT, 8'h00, 8'h00);
    send_op(brd_pkg::OP_POP_BACK, 8'h00, 8'h00);
    send_op(brd_pkg::OP_POP_FRONT, 8'h00, 8'h00);
    send_op(brd_pkg::OP_POP_BACK, 8'h00, 8'h00);
    send_op(brd_pkg::OP_PUSH_FRONT, 8'h81, 8'h00);
    send_op(brd_pkg::OP_POP_BACK, 8'h00, 8'h00);
    send_op(brd_pkg::OP_PUSH_FRONT, 8'h7e, 8'h00);
    send_op(brd_pkg::OP_POP_FRONT, 8'h00, 8'h00);

    sent = 0;
    burst_left = 0;
    mode = MODE_FILL;
    linger = 0;
    mix_left = 0;
    while (sent < ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      // fill to the top, stay there a while, drain to empty, then wander
      case (mode)
        MODE_FILL: begin
          if (tr.count == CAP) linger++;
          if (linger > 15) begin
            mode = MODE_DRAIN;
            linger = 0;
          end
        end
        MODE_DRAIN: begin
          if (tr.count == 0) linger++;
          if (linger > 15) begin
            mode = MODE_MIX;
            linger = 0;
            mix_left = 150;
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) mode = MODE_FILL;
        end
      endcase
      send(pick(mode));
      sent++;
      burst_left--;
    end
    start <= 1'b0;

    while (tr.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tr.errors == 0 && tr.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
